/* hw/rtl/crcfr_pkg.sv */
`timescale 1ns / 1ps

package crcfr_pkg;

    // Frame constants.
    localparam logic [15:0] CRC_POLY     = 16'h1021;
    localparam logic [7:0]  MIN_TOTAL    = 8'd5;
    localparam logic [7:0]  MARKER_RESET = 8'hFF;
    localparam int          QUEUE_DEPTH  = 4;

    // Register word index on the configuration port.
    localparam logic REG_START_MARKER = 1'b0;

    // Result kinds.
    localparam logic [1:0] KIND_PAYLOAD = 2'd0;
    localparam logic [1:0] KIND_GOOD    = 2'd1;
    localparam logic [1:0] KIND_BAD_CRC = 2'd2;
    localparam logic [1:0] KIND_LEN_ERR = 2'd3;

    // Role of a frame byte, as classified by the front end.
    typedef enum logic [2:0] {
        BK_START   = 3'd0,
        BK_CODE    = 3'd1,
        BK_LEN     = 3'd2,
        BK_PAYLOAD = 3'd3,
        BK_CRC_HI  = 3'd4,
        BK_CRC_LO  = 3'd5,
        BK_LEN_ERR = 3'd6
    } t_bkind;

    // Request passed from the front end to the back end.
    typedef struct packed {
        t_bkind     bkind;
        logic [7:0] data;
        logic [7:0] code;
        logic [7:0] index;
        logic [7:0] count;
    } t_req;

    // Result item.
    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] code;
        logic [7:0] value;
        logic [7:0] index;
        logic [7:0] count;
    } t_res;

    // One byte of CRC-16 (polynomial 0x1021, MSB first).
    function automatic logic [15:0] crc_feed(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {b, 8'h00};
        for (int k = 0; k < 8; k++) begin
            if (c[15]) begin
                c = {c[14:0], 1'b0} ^ CRC_POLY;
            end else begin
                c = {c[14:0], 1'b0};
            end
        end
        return c;
    endfunction

endpackage

/* hw/rtl/crcfr_fifo.sv */
`timescale 1ns / 1ps

module crcfr_fifo
    import crcfr_pkg::*;
#(
    parameter int WIDTH = 8,
    parameter int DEPTH = QUEUE_DEPTH
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_full,
    input  logic             i_pop,
    output logic [WIDTH-1:0] o_data,
    output logic             o_empty
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [AW-1:0]    r_wr_ptr;
    logic [AW-1:0]    r_rd_ptr;
    logic [CW-1:0]    r_count;

    logic do_push;
    logic do_pop;

    assign o_full  = (r_count == CW'(DEPTH));
    assign o_empty = (r_count == '0);
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;
    assign o_data  = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= (r_wr_ptr == AW'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= (r_rd_ptr == AW'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (do_pop && !do_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

/* hw/rtl/crcfr_front.sv */
`timescale 1ns / 1ps

module crcfr_front
    import crcfr_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_take,
    input  logic [7:0] i_byte,
    input  logic [7:0] i_marker,
    output logic       o_req_valid,
    output t_req       o_req
);

    logic [7:0] r_pos;
    logic [7:0] r_total;
    logic [7:0] r_code;
    logic [7:0] n_pos;
    logic [7:0] n_total;
    logic [7:0] n_code;

    logic [8:0] pos_ext;
    logic [8:0] total_ext;

    assign pos_ext   = {1'b0, r_pos};
    assign total_ext = {1'b0, r_total};

    always_comb begin
        n_pos       = r_pos;
        n_total     = r_total;
        n_code      = r_code;
        o_req_valid = 1'b0;
        o_req       = '0;
        o_req.bkind = BK_START;
        o_req.data  = i_byte;
        o_req.code  = r_code;
        if (i_take) begin
            if (r_pos == 8'd0) begin
                // Hunting: only the start marker opens a frame.
                if (i_byte == i_marker) begin
                    o_req_valid = 1'b1;
                    o_req.bkind = BK_START;
                    n_pos       = 8'd1;
                end
            end else if (r_pos == 8'd1) begin
                o_req_valid = 1'b1;
                o_req.bkind = BK_CODE;
                n_code      = i_byte;
                n_pos       = 8'd2;
            end else if (r_pos == 8'd2) begin
                o_req_valid = 1'b1;
                if (i_byte < MIN_TOTAL) begin
                    o_req.bkind = BK_LEN_ERR;
                    o_req.data  = 8'd0;
                    n_pos       = 8'd0;
                end else begin
                    o_req.bkind = BK_LEN;
                    n_total     = i_byte;
                    n_pos       = 8'd3;
                end
            end else begin
                o_req_valid = 1'b1;
                o_req.count = r_total - MIN_TOTAL;
                if (pos_ext + 9'd3 <= total_ext) begin
                    o_req.bkind = BK_PAYLOAD;
                    o_req.index = r_pos - 8'd3;
                    n_pos       = r_pos + 8'd1;
                end else if (pos_ext + 9'd2 == total_ext) begin
                    o_req.bkind = BK_CRC_HI;
                    n_pos       = r_pos + 8'd1;
                end else begin
                    o_req.bkind = BK_CRC_LO;
                    n_pos       = 8'd0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos   <= 8'd0;
            r_total <= 8'd0;
            r_code  <= 8'd0;
        end else begin
            r_pos   <= n_pos;
            r_total <= n_total;
            r_code  <= n_code;
        end
    end

endmodule

/* hw/rtl/crcfr_back.sv */
`timescale 1ns / 1ps

module crcfr_back
    import crcfr_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_req_valid,
    input  t_req i_req,
    input  logic i_room,
    output logic o_req_pop,
    output logic o_res_valid,
    output t_res o_res
);

    logic [15:0] r_crc;
    logic [7:0]  r_crc_hi;
    logic [15:0] n_crc;
    logic [7:0]  n_crc_hi;
    logic [15:0] crc_in;
    logic [15:0] crc_step;
    logic        crc_ok;

    // Every request yields at most one result, so one free slot suffices.
    assign o_req_pop = i_req_valid && i_room;

    assign crc_in   = (i_req.bkind == BK_START) ? 16'h0000 : r_crc;
    assign crc_step = crc_feed(crc_in, i_req.data);
    assign crc_ok   = (r_crc_hi == r_crc[15:8]) && (i_req.data == r_crc[7:0]);

    always_comb begin
        n_crc       = r_crc;
        n_crc_hi    = r_crc_hi;
        o_res_valid = 1'b0;
        o_res       = '0;
        o_res.code  = i_req.code;
        if (o_req_pop) begin
            case (i_req.bkind)
                BK_START, BK_CODE, BK_LEN: begin
                    n_crc = crc_step;
                end
                BK_PAYLOAD: begin
                    n_crc       = crc_step;
                    o_res_valid = 1'b1;
                    o_res.kind  = KIND_PAYLOAD;
                    o_res.value = i_req.data;
                    o_res.index = i_req.index;
                    o_res.count = i_req.count;
                end
                BK_CRC_HI: begin
                    n_crc_hi = i_req.data;
                end
                BK_CRC_LO: begin
                    o_res_valid = 1'b1;
                    o_res.kind  = crc_ok ? KIND_GOOD : KIND_BAD_CRC;
                    o_res.count = i_req.count;
                end
                BK_LEN_ERR: begin
                    o_res_valid = 1'b1;
                    o_res.kind  = KIND_LEN_ERR;
                end
                default: begin
                    n_crc = r_crc;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_crc    <= 16'h0000;
            r_crc_hi <= 8'h00;
        end else begin
            r_crc    <= n_crc;
            r_crc_hi <= n_crc_hi;
        end
    end

endmodule

/* hw/rtl/crc16_frame_receiver_unit.sv */
`timescale 1ns / 1ps

// Serial frame deframer with CRC-16 check (polynomial 0x1021, initial value zero).
// Throughput: one byte per cycle while the request queue has room, limited by the
// single CRC byte step in the back end. A byte that causes a result passes via the
// request queue and back end into the result queue, then shows on the result ports.
// Reset (synchronous, active low) empties both queues, returns the parser to hunting,
// clears the CRC state and sets the start marker to 0xFF.
module crc16_frame_receiver_unit
    import crcfr_pkg::*;
#(
    parameter int QDEPTH = QUEUE_DEPTH
) (
    input  logic        i_clk,
    input  logic        i_rst_n,

    // Byte input, queue style.
    input  logic        push,
    output logic        full,
    input  logic [7:0]  i_in_byte,

    // Result output, queue style.
    output logic        empty,
    input  logic        pop,
    output logic [1:0]  o_result_kind,
    output logic [7:0]  o_order_code,
    output logic [7:0]  o_payload_value,
    output logic [7:0]  o_payload_index,
    output logic [7:0]  o_payload_count,

    // Configuration port.
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    // The start marker register lives here; the front end compares every byte against it
    // while hunting. The user must write it only while the block is idle; not enforced.
    logic [7:0] r_start_marker;
    logic       cfg_write;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start_marker <= MARKER_RESET;
        end else if (cfg_write && (paddr[2] == REG_START_MARKER)) begin
            r_start_marker <= pwdata[7:0];
        end
    end

    always_comb begin
        prdata = 32'h0000_0000;
        if (paddr[2] == REG_START_MARKER) begin
            prdata = {24'h00_0000, r_start_marker};
        end
    end

    // The front end parses the byte stream and classifies each frame byte. Bytes
    // seen while hunting that do not match the marker are dropped right there.
    logic take;
    logic front_valid;
    t_req front_req;

    assign take = push && !full;

    crcfr_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_take      (take),
        .i_byte      (i_in_byte),
        .i_marker    (r_start_marker),
        .o_req_valid (front_valid),
        .o_req       (front_req)
    );

    // The request queue decouples parsing from the CRC work, so input can keep
    // flowing while the result side is stalled, until the request queue is full.
    logic [$bits(t_req)-1:0] mid_data;
    logic                    mid_empty;
    logic                    mid_pop;
    t_req                    back_req;

    crcfr_fifo #(
        .WIDTH ($bits(t_req)),
        .DEPTH (QDEPTH)
    ) u_req_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (front_valid),
        .i_data  (front_req),
        .o_full  (full),
        .i_pop   (mid_pop),
        .o_data  (mid_data),
        .o_empty (mid_empty)
    );

    assign back_req = t_req'(mid_data);

    // The back end runs the CRC, keeps the received CRC high byte and builds
    // the result items.
    logic out_full;
    logic res_valid;
    t_res back_res;

    crcfr_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (!mid_empty),
        .i_req       (back_req),
        .i_room      (!out_full),
        .o_req_pop   (mid_pop),
        .o_res_valid (res_valid),
        .o_res       (back_res)
    );

    // The result queue holds finished results until the consumer pops them.
    logic [$bits(t_res)-1:0] out_data;
    t_res                    out_res;

    crcfr_fifo #(
        .WIDTH ($bits(t_res)),
        .DEPTH (QDEPTH)
    ) u_res_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (res_valid),
        .i_data  (back_res),
        .o_full  (out_full),
        .i_pop   (pop),
        .o_data  (out_data),
        .o_empty (empty)
    );

    assign out_res         = t_res'(out_data);
    assign o_result_kind   = out_res.kind;
    assign o_order_code    = out_res.code;
    assign o_payload_value = out_res.value;
    assign o_payload_index = out_res.index;
    assign o_payload_count = out_res.count;

endmodule

/* tb/sv/tb_crc16_frame_receiver_unit.sv */
`timescale 1ns / 1ps

// Testbench for the CRC-16 frame receiver. Bytes are pushed one request at a time, a
// behavioral deframer tracks the block's state and queues the results that each byte
// should cause, and a separate process pops results and compares them in order.
module tb_crc16_frame_receiver_unit;
    import crcfr_pkg::*;

    localparam int         CLK_PERIOD     = 10;
    localparam int         DRAIN_CYCLES   = 16;
    localparam int         WATCHDOG_LIMIT = 2000;
    localparam int         MAX_REPORTS    = 10;
    localparam logic [2:0] MARKER_ADDR    = {REG_START_MARKER, 2'b00};

    logic        i_clk;
    logic        i_rst_n;
    logic        push;
    logic        full;
    logic [7:0]  i_in_byte;
    logic        empty;
    logic        pop;
    logic [1:0]  o_result_kind;
    logic [7:0]  o_order_code;
    logic [7:0]  o_payload_value;
    logic [7:0]  o_payload_index;
    logic [7:0]  o_payload_count;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    // Shadow of the deframer state, updated once for every accepted byte.
    logic [7:0]  marker_cfg;
    logic [7:0]  rx_pos;
    logic [7:0]  len_total;
    logic [7:0]  cur_code;
    logic [15:0] crc_acc;
    logic [7:0]  crc_hi_rx;

    // Results that accepted bytes have caused and that have not been popped yet.
    t_res        frame_events_due[$];

    // Payload of the next frame to be sent.
    logic [7:0]  payload_buf[$];

    int          errors;
    int          framed_bytes;
    int          idle_cycles;
    bit          no_idle;

    crc16_frame_receiver_unit u_top (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .push           (push),
        .full           (full),
        .i_in_byte      (i_in_byte),
        .empty          (empty),
        .pop            (pop),
        .o_result_kind  (o_result_kind),
        .o_order_code   (o_order_code),
        .o_payload_value(o_payload_value),
        .o_payload_index(o_payload_index),
        .o_payload_count(o_payload_count),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready)
    );

    initial begin
        i_clk = 1'b0;
        forever #(CLK_PERIOD / 2) i_clk = ~i_clk;
    end

    // CRC-16 with polynomial 0x1021, shifted in one message bit at a time, MSB first.
    function automatic logic [15:0] crc_next(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        logic        fb;
        c = crc;
        for (int i = 7; i >= 0; i--) begin
            fb = c[15] ^ b[i];
            c  = {c[14:0], 1'b0};
            if (fb) begin
                c = c ^ CRC_POLY;
            end
        end
        return c;
    endfunction

    // Mostly short payloads so that frames end often; now and then a longer one.
    function automatic int pick_payload_len();
        if ($urandom_range(0, 19) == 0) begin
            return $urandom_range(13, 60);
        end
        return $urandom_range(0, 12);
    endfunction

    task automatic note_failure(input string what);
        errors++;
        if (errors <= MAX_REPORTS) begin
            $display("ERROR at %0t: %s", $realtime, what);
        end
    endtask

    // Walks the frame state machine for one accepted byte. Hunting bytes other than the
    // marker vanish, a length below five aborts the frame, payload bytes come out with
    // their index, and the CRC low byte closes the frame with a good or bad end.
    task automatic track_frame_byte(input logic [7:0] b);
        t_res ev;
        int   nxt;
        ev = '0;
        if (rx_pos == 8'd0) begin
            if (b == marker_cfg) begin
                crc_acc = crc_next(16'h0000, b);
                rx_pos  = 8'd1;
            end
        end else if (rx_pos == 8'd1) begin
            cur_code = b;
            crc_acc  = crc_next(crc_acc, b);
            rx_pos   = 8'd2;
        end else if (rx_pos == 8'd2) begin
            if (b < MIN_TOTAL) begin
                rx_pos  = 8'd0;
                ev.kind = KIND_LEN_ERR;
                ev.code = cur_code;
                frame_events_due.push_back(ev);
            end else begin
                len_total = b;
                crc_acc   = crc_next(crc_acc, b);
                rx_pos    = 8'd3;
            end
        end else begin
            nxt = int'(rx_pos) + 1;
            if (nxt + 2 <= int'(len_total)) begin
                crc_acc  = crc_next(crc_acc, b);
                rx_pos   = 8'(nxt);
                ev.kind  = KIND_PAYLOAD;
                ev.code  = cur_code;
                ev.value = b;
                ev.index = 8'(nxt - 4);
                ev.count = len_total - MIN_TOTAL;
                frame_events_due.push_back(ev);
            end else if (nxt + 1 == int'(len_total)) begin
                crc_hi_rx = b;
                rx_pos    = 8'(nxt);
            end else begin
                rx_pos  = 8'd0;
                ev.kind = (crc_hi_rx == crc_acc[15:8] && b == crc_acc[7:0]) ?
                          KIND_GOOD : KIND_BAD_CRC;
                ev.code  = cur_code;
                ev.count = len_total - MIN_TOTAL;
                frame_events_due.push_back(ev);
            end
        end
    endtask

    // Sends one byte request. It starts and ends at a falling edge and leaves push high,
    // so back-to-back bytes keep push asserted without a glitch. Whoever waits next
    // lowers push first.
    task automatic send_byte(input logic [7:0] b);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, 7);
        if (gap > 0) begin
            push = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        push      = 1'b1;
        i_in_byte = b;
        @(posedge i_clk);
        while (full) @(posedge i_clk);
        track_frame_byte(b);
        @(negedge i_clk);
    endtask

    // Sends a complete frame around payload_buf with its CRC, optionally with one CRC
    // bit flipped so that the frame must end as a mismatch.
    task automatic send_frame(input logic [7:0] code, input bit corrupt);
        logic [15:0] c;
        logic [7:0]  total;
        total = 8'(payload_buf.size()) + MIN_TOTAL;
        c = crc_next(16'h0000, marker_cfg);
        c = crc_next(c, code);
        c = crc_next(c, total);
        foreach (payload_buf[i]) begin
            c = crc_next(c, payload_buf[i]);
        end
        if (corrupt) begin
            c = c ^ (16'h0001 << $urandom_range(0, 15));
        end
        send_byte(marker_cfg);
        send_byte(code);
        send_byte(total);
        foreach (payload_buf[i]) begin
            send_byte(payload_buf[i]);
        end
        send_byte(c[15:8]);
        send_byte(c[7:0]);
        framed_bytes += payload_buf.size() + 5;
    endtask

    task automatic fill_payload(input int n);
        payload_buf.delete();
        repeat (n) payload_buf.push_back(8'($urandom_range(0, 255)));
    endtask

    // Stops sending and waits until every queued result has been popped, then lets the
    // block settle, since the CRC high byte and ignored bytes cause no result.
    task automatic wait_drained();
        push = 1'b0;
        while (frame_events_due.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    // APB write of the start marker: setup cycle, then access cycle until pready.
    task automatic cfg_write_marker(input logic [7:0] v);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b1;
        paddr   = MARKER_ADDR;
        pwdata  = {24'h0, v};
        @(negedge i_clk);
        penable = 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        marker_cfg = v;
        @(negedge i_clk);
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
    endtask

    task automatic cfg_read_check();
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b0;
        paddr   = MARKER_ADDR;
        @(negedge i_clk);
        penable = 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        if (prdata !== {24'h0, marker_cfg}) begin
            note_failure($sformatf("start marker reads %08h, expected %02h",
                                   prdata, marker_cfg));
        end
        @(negedge i_clk);
        psel    = 1'b0;
        penable = 1'b0;
    endtask

    // Compares one popped result with the oldest expectation, field by field.
    task automatic check_result();
        t_res want;
        if (frame_events_due.size() == 0) begin
            note_failure($sformatf("unexpected result kind=%0d code=%02h value=%02h",
                                   o_result_kind, o_order_code, o_payload_value));
            return;
        end
        want = frame_events_due.pop_front();
        if (o_result_kind !== want.kind || o_order_code !== want.code ||
            o_payload_value !== want.value || o_payload_index !== want.index ||
            o_payload_count !== want.count) begin
            note_failure($sformatf(
                "expected kind=%0d code=%02h value=%02h index=%0d count=%0d, got %0d %02h %02h %0d %0d",
                want.kind, want.code, want.value, want.index, want.count,
                o_result_kind, o_order_code, o_payload_value, o_payload_index,
                o_payload_count));
        end
    endtask

    // Result side: stalls a random number of cycles before each pop, except during the
    // stretches where both sides run flat out.
    initial begin : result_popper
        int stall;
        pop = 1'b0;
        @(posedge i_rst_n);
        @(negedge i_clk);
        forever begin
            stall = no_idle ? 0 : $urandom_range(0, 7);
            if (stall > 0) begin
                pop = 1'b0;
                repeat (stall) @(negedge i_clk);
            end
            pop = 1'b1;
            @(posedge i_clk);
            while (empty) @(posedge i_clk);
            check_result();
            @(negedge i_clk);
        end
    end

    // The watchdog ends a run in which no request moves on either side for too long.
    initial begin : watchdog
        idle_cycles = 0;
        @(posedge i_rst_n);
        forever begin
            @(posedge i_clk);
            if ((push && !full) || (pop && !empty)) begin
                idle_cycles = 0;
            end else begin
                idle_cycles++;
            end
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("Timeout: no request accepted for %0d cycles", WATCHDOG_LIMIT);
                $display("Simulation FAILED");
                $finish;
            end
        end
    end

    // The marker must read back as 0xFF straight after reset.
    task automatic test_reset_marker();
        cfg_read_check();
    endtask

    // While hunting, anything but the marker is dropped without a result.
    task automatic test_hunt_noise();
        send_byte(8'h00);
        send_byte(8'h7F);
        send_byte(8'hFE);
    endtask

    // Lengths of four and zero abort the frame and report the order code.
    task automatic test_length_error();
        send_byte(marker_cfg);
        send_byte(8'h00);
        send_byte(8'h04);
        send_byte(marker_cfg);
        send_byte(8'hFF);
        send_byte(8'h00);
    endtask

    // With a length of five the two bytes after the length are already the CRC.
    task automatic test_empty_frame();
        payload_buf.delete();
        send_frame(8'h5A, 1'b0);
    endtask

    // A marker byte and a zero byte inside the payload are plain data, and a flipped
    // CRC bit has to end the frame as a mismatch.
    task automatic test_bad_crc();
        payload_buf.delete();
        payload_buf.push_back(marker_cfg);
        payload_buf.push_back(8'h00);
        send_frame(8'hC3, 1'b1);
    endtask

    // Both sides without gaps, with one pause in the middle until all results are out.
    task automatic test_back_to_back();
        no_idle = 1'b1;
        repeat (6) begin
            fill_payload(pick_payload_len());
            send_frame(8'($urandom_range(0, 255)), $urandom_range(0, 3) == 0);
        end
        wait_drained();
        repeat (6) begin
            fill_payload(pick_payload_len());
            send_frame(8'($urandom_range(0, 255)), $urandom_range(0, 3) == 0);
        end
        wait_drained();
        no_idle = 1'b0;
    endtask

    // The longest frame the length byte allows: 250 payload bytes, index up to 249.
    task automatic test_long_frame();
        fill_payload(250);
        send_frame(8'hFF, 1'b0);
    endtask

    // One run of random traffic: mostly well-formed frames with random content, plus
    // corrupted CRCs, length errors, loose bytes and frames cut short.
    task automatic random_traffic(input int n_bytes);
        int start;
        int r;
        start = framed_bytes;
        while (framed_bytes - start < n_bytes) begin
            r = $urandom_range(0, 99);
            if (r < 80) begin
                fill_payload(pick_payload_len());
                send_frame(8'($urandom_range(0, 255)), r >= 65);
            end else if (r < 86) begin
                send_byte(marker_cfg);
                send_byte(8'($urandom_range(0, 255)));
                send_byte(8'($urandom_range(0, 4)));
                framed_bytes += 3;
            end else if (r < 93) begin
                repeat ($urandom_range(1, 3)) send_byte(8'($urandom_range(0, 255)));
            end else begin
                send_byte(marker_cfg);
                send_byte(8'($urandom_range(0, 255)));
                send_byte(8'($urandom_range(0, 255)));
                repeat ($urandom_range(0, 6)) send_byte(8'($urandom_range(0, 255)));
                framed_bytes += 3;
            end
        end
    endtask

    // Random traffic under several start markers, the extremes among them. Each write
    // happens with the block drained and is checked by a read.
    task automatic test_marker_settings();
        logic [7:0] markers[4];
        markers[0] = 8'h00;
        markers[1] = 8'($urandom_range(1, 254));
        markers[2] = 8'hFF;
        markers[3] = 8'($urandom_range(0, 255));
        foreach (markers[i]) begin
            wait_drained();
            cfg_write_marker(markers[i]);
            cfg_read_check();
            random_traffic(120);
        end
    endtask

    initial begin
        i_rst_n    = 1'b0;
        push       = 1'b0;
        i_in_byte  = 8'h00;
        psel       = 1'b0;
        penable    = 1'b0;
        pwrite     = 1'b0;
        paddr      = '0;
        pwdata     = '0;
        errors       = 0;
        framed_bytes = 0;
        no_idle      = 1'b0;
        marker_cfg = MARKER_RESET;
        rx_pos     = 8'd0;
        len_total  = 8'd0;
        cur_code   = 8'd0;
        crc_acc    = 16'h0000;
        crc_hi_rx  = 8'd0;

        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        test_reset_marker();
        test_hunt_noise();
        test_length_error();
        test_empty_frame();
        test_bad_crc();
        test_back_to_back();
        test_long_frame();
        test_marker_settings();

        // Everything sent; wait for the last results and give the block time to show
        // any stray one.
        wait_drained();
        if (frame_events_due.size() != 0) begin
            note_failure("results still expected at the end of the run");
        end
        if (errors == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
